// File: hdl/kvt_pkg.sv
// Package for the keyed vote tally table: field widths, command codes,
// sequencer states and the transfer structs. No dependencies.
`default_nettype none

package kvt_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_ENTRIES_DEF = 16;
	localparam int TALLY_WIDTH_DEF = 16;

	// Fixed field widths of the transfer structs.
	localparam int DIGITS_W    = 7;
	localparam int SLOT_W      = 4;
	localparam int TALLY_OUT_W = 16;
	localparam int USED_W      = 5;
	localparam int KEY_W       = 2 * DIGITS_W + 1;

	// Command codes.
	localparam logic CMD_VOTE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MISS,
		ST_READ
	} state_t;

	// Key as held in one table entry.
	typedef struct packed {
		logic [DIGITS_W-1:0] prefix;
		logic [DIGITS_W-1:0] suffix;
		logic                is_long;
	} key_t;

	typedef struct packed {
		logic                cmd;
		logic [DIGITS_W-1:0] key_prefix;
		logic [DIGITS_W-1:0] key_suffix;
		logic                key_long;
		logic [SLOT_W-1:0]   read_index;
	} item_t;

	typedef struct packed {
		logic [SLOT_W-1:0]      slot;
		logic                   inserted;
		logic                   rejected_full;
		logic                   slot_valid;
		logic [TALLY_OUT_W-1:0] tally;
		logic [DIGITS_W-1:0]    stored_prefix;
		logic [DIGITS_W-1:0]    stored_suffix;
		logic                   stored_long;
		logic [USED_W-1:0]      used_entries;
	} result_t;

endpackage

`default_nettype wire

// File: hdl/kvt_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module kvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// File: hdl/kvt_match.sv
// Shared compare unit: matches one stored entry against the vote key and
// forms the saturated next tally. Depends on kvt_pkg.
`default_nettype none

module kvt_match #(
	parameter int TALLY_WIDTH = kvt_pkg::TALLY_WIDTH_DEF
) (
	input  wire kvt_pkg::key_t         stored_key,
	input  wire logic [TALLY_WIDTH-1:0] stored_tally,
	input  wire kvt_pkg::key_t         vote_key,
	output logic                        hit,
	output logic      [TALLY_WIDTH-1:0] tally_next
);

	// A short stored key matches on the prefix alone; a long one also
	// needs a long vote with the same suffix.
	assign hit = (stored_key.prefix == vote_key.prefix) &&
		(!stored_key.is_long ||
		 (vote_key.is_long && (stored_key.suffix == vote_key.suffix)));

	assign tally_next = (&stored_tally) ? stored_tally
		: stored_tally + TALLY_WIDTH'(1);

endmodule

`default_nettype wire

// File: hdl/keyed_vote_tally_table_unit.sv
// Top level of the keyed vote tally table: sequencer, fill count and result
// register around one entry RAM and the shared compare unit.
// Depends on kvt_pkg, kvt_ram and kvt_match.
//
// Channel   Direction  Signals             Handshake
// -------   ---------  -------             ---------
// item      in         start, item, busy   transfer when start is high and busy is low
// result    out        done, result        transfer in every cycle that done is high
//
// A read fetches its entry through the RAM read port while still idle.
// A vote searches the filled entries in order and stops at the first
// match; on a miss, the miss step inserts the key or rejects a full table.
// The entries are read one per cycle through the single RAM read port and
// checked in the next cycle by the compare unit.
// Reset clears the sequencer, fill count and strobe; no clearing pass is
// needed since only entries below the fill count are ever looked at.
// busy falls in the cycle that done rises, so the next item may transfer
// while the previous result is shown. The receiver cannot stall.
`default_nettype none

module keyed_vote_tally_table_unit #(
	parameter int MAX_ENTRIES = kvt_pkg::MAX_ENTRIES_DEF,
	parameter int TALLY_WIDTH = kvt_pkg::TALLY_WIDTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire kvt_pkg::item_t  item,
	output logic                 busy,
	output logic                 done,
	output kvt_pkg::result_t     result
);

	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > kvt_pkg::SLOT_W) ? CNT_W : kvt_pkg::SLOT_W;
	localparam int WORD_W = kvt_pkg::KEY_W + TALLY_WIDTH;

	// Width adapters: low bits of a wider value, zero extension of a narrower one.
	function automatic logic [kvt_pkg::SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] pos);
		logic [IDX_W+kvt_pkg::SLOT_W-1:0] w;
		w = {{kvt_pkg::SLOT_W{1'b0}}, pos};
		return w[kvt_pkg::SLOT_W-1:0];
	endfunction

	function automatic logic [kvt_pkg::TALLY_OUT_W-1:0] tally_of(
		input logic [TALLY_WIDTH-1:0] t);
		logic [TALLY_WIDTH+kvt_pkg::TALLY_OUT_W-1:0] w;
		w = {{kvt_pkg::TALLY_OUT_W{1'b0}}, t};
		return w[kvt_pkg::TALLY_OUT_W-1:0];
	endfunction

	function automatic logic [kvt_pkg::USED_W-1:0] used_of(input logic [CNT_W-1:0] n);
		logic [CNT_W+kvt_pkg::USED_W-1:0] w;
		w = {{kvt_pkg::USED_W{1'b0}}, n};
		return w[kvt_pkg::USED_W-1:0];
	endfunction

	kvt_pkg::state_t  state_q, state_d;
	kvt_pkg::item_t   item_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] issue_q;
	logic             cmp_valid_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             done_q;
	kvt_pkg::result_t result_q, result_d;
	logic             load_result;
	logic             insert;

	// RAM ports.
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [IDX_W-1:0]  rd_addr;
	logic [WORD_W-1:0] rd_data;

	kvt_pkg::key_t          rd_key;
	logic [TALLY_WIDTH-1:0] rd_tally;
	kvt_pkg::key_t          vote_key;
	logic                   match_hit;
	logic [TALLY_WIDTH-1:0] tally_inc;

	logic                       cmp_hit;
	logic                       scan_issue;
	logic                       scan_done;
	logic                       table_full;
	logic                       read_valid;
	logic [IDX_W+kvt_pkg::SLOT_W-1:0] in_idx_ext;
	logic [IDX_W+kvt_pkg::SLOT_W-1:0] q_idx_ext;

	kvt_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_key   = kvt_pkg::key_t'(rd_data[WORD_W-1 -: kvt_pkg::KEY_W]);
	assign rd_tally = rd_data[TALLY_WIDTH-1:0];

	assign vote_key.prefix  = item_q.key_prefix;
	assign vote_key.suffix  = item_q.key_suffix;
	assign vote_key.is_long = item_q.key_long;

	kvt_match #(
		.TALLY_WIDTH (TALLY_WIDTH)
	) u_match (
		.stored_key   (rd_key),
		.stored_tally (rd_tally),
		.vote_key     (vote_key),
		.hit          (match_hit),
		.tally_next   (tally_inc)
	);

	// The search issues one RAM read per cycle; the compare of the entry read
	// in the previous cycle runs alongside. A hit stops the issue at once.
	assign cmp_hit    = cmp_valid_s1 && match_hit;
	assign scan_issue = (state_q == kvt_pkg::ST_SCAN) && (issue_q < fill_q) && !cmp_hit;
	assign scan_done  = (state_q == kvt_pkg::ST_SCAN) && (issue_q == fill_q) && !cmp_hit;
	assign table_full = (fill_q == CNT_W'(MAX_ENTRIES));

	// Read positions at or beyond the fill count hold nothing.
	assign read_valid = CMP_W'(item_q.read_index) < CMP_W'(fill_q);

	assign in_idx_ext = {{IDX_W{1'b0}}, item.read_index};
	assign q_idx_ext  = {{IDX_W{1'b0}}, item_q.read_index};

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			kvt_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (item.cmd == kvt_pkg::CMD_READ) ? kvt_pkg::ST_READ
						: kvt_pkg::ST_SCAN;
				end
			end
			kvt_pkg::ST_SCAN: begin
				if (cmp_hit) begin
					state_d = kvt_pkg::ST_IDLE;
				end else if (scan_done) begin
					state_d = kvt_pkg::ST_MISS;
				end
			end
			kvt_pkg::ST_MISS: state_d = kvt_pkg::ST_IDLE;
			kvt_pkg::ST_READ: state_d = kvt_pkg::ST_IDLE;
			default:          state_d = kvt_pkg::ST_IDLE;
		endcase
	end

	// Output and datapath control.
	always_comb begin
		busy        = (state_q != kvt_pkg::ST_IDLE);
		wr_en       = 1'b0;
		wr_addr     = fill_q[IDX_W-1:0];
		wr_data     = {vote_key, TALLY_WIDTH'(1)};
		insert      = 1'b0;
		load_result = 1'b0;
		result_d    = '0;
		// In idle the read port already fetches the entry a read command asks for.
		rd_addr     = (state_q == kvt_pkg::ST_IDLE) ? in_idx_ext[IDX_W-1:0]
			: issue_q[IDX_W-1:0];
		case (state_q)
			kvt_pkg::ST_SCAN: begin
				if (cmp_hit) begin
					wr_en                  = 1'b1;
					wr_addr                = cmp_idx_s1;
					wr_data                = {rd_key, tally_inc};
					load_result            = 1'b1;
					result_d.slot          = slot_of(cmp_idx_s1);
					result_d.slot_valid    = 1'b1;
					result_d.tally         = tally_of(tally_inc);
					result_d.stored_prefix = rd_key.prefix;
					result_d.stored_suffix = rd_key.suffix;
					result_d.stored_long   = rd_key.is_long;
					result_d.used_entries  = used_of(fill_q);
				end
			end
			kvt_pkg::ST_MISS: begin
				load_result = 1'b1;
				if (table_full) begin
					result_d.rejected_full = 1'b1;
					result_d.used_entries  = used_of(fill_q);
				end else begin
					wr_en                  = 1'b1;
					insert                 = 1'b1;
					result_d.slot          = slot_of(fill_q[IDX_W-1:0]);
					result_d.inserted      = 1'b1;
					result_d.slot_valid    = 1'b1;
					result_d.tally         = tally_of(TALLY_WIDTH'(1));
					result_d.stored_prefix = vote_key.prefix;
					result_d.stored_suffix = vote_key.suffix;
					result_d.stored_long   = vote_key.is_long;
					result_d.used_entries  = used_of(fill_q + CNT_W'(1));
				end
			end
			kvt_pkg::ST_READ: begin
				load_result           = 1'b1;
				result_d.slot         = q_idx_ext[kvt_pkg::SLOT_W-1:0];
				result_d.slot_valid   = read_valid;
				result_d.used_entries = used_of(fill_q);
				if (read_valid) begin
					result_d.tally         = tally_of(rd_tally);
					result_d.stored_prefix = rd_key.prefix;
					result_d.stored_suffix = rd_key.suffix;
					result_d.stored_long   = rd_key.is_long;
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kvt_pkg::ST_IDLE;
			fill_q       <= '0;
			issue_q      <= '0;
			cmp_valid_s1 <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			cmp_valid_s1 <= scan_issue;
			done_q       <= load_result;
			if (insert) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (state_q == kvt_pkg::ST_IDLE) begin
				issue_q <= '0;
			end else if (scan_issue) begin
				issue_q <= issue_q + CNT_W'(1);
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if ((state_q == kvt_pkg::ST_IDLE) && start) begin
			item_q <= item;
		end
		cmp_idx_s1 <= issue_q[IDX_W-1:0];
		if (load_result) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// The fill count never passes the table size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_ENTRIES))
		else $error("fill count beyond table size");

	// Only the miss step may change the fill count.
	a_fill_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != kvt_pkg::ST_MISS) |=> $stable(fill_q))
		else $error("fill count changed outside the miss step");

	// A pending compare exists only while searching.
	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_valid_s1 |-> (state_q == kvt_pkg::ST_SCAN))
		else $error("compare pending outside the search");

	// Finishing an item always shows its result, and results never repeat.
	a_done_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("item finished without a result");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

endmodule

`default_nettype wire
